>>> rtl/mhed_pkg.sv
`default_nettype none

package mhed_pkg;

    // Fixed field widths
    localparam int CH_W      = 3;
    localparam int SMP_W     = 12;
    localparam int LVL_W     = 12;
    localparam int SUM_W     = 17;
    localparam int CFG_IDX_W = 1;

    // Defaults for the top-level parameters
    localparam int DEF_CHANNELS         = 6;
    localparam int DEF_BASELINE_SAMPLES = 20;

    // Reset values of the level registers
    localparam logic [LVL_W-1:0] DEF_TRIGGER = 12'd80;
    localparam logic [LVL_W-1:0] DEF_RELEASE = 12'd40;

    // Depth of the request queue and the result queue (power of two)
    localparam int QUEUE_DEPTH = 4;

    // Shift of the reciprocal multiply that forms the baseline mean
    localparam int DIV_SHIFT = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRIGGER = 1'b0,
        REG_RELEASE = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [SMP_W-1:0] sample;
        logic             in_range;
    } t_item;

    typedef struct packed {
        logic [CH_W-1:0]  channel_echo;
        logic             calibrating;
        logic             event_res;
        logic             active;
        logic [SMP_W-1:0] difference;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/mhed_fifo.sv
`default_nettype none

module mhed_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic              o_empty,
    output logic [W-1:0]      o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/mhed_front.sv
`default_nettype none

module mhed_front #(
    parameter int CHANNELS = 6
) (
    input  wire logic                        i_push,
    input  wire logic [mhed_pkg::CH_W-1:0]   i_channel,
    input  wire logic [mhed_pkg::SMP_W-1:0]  i_sample,
    output logic                             o_full,
    input  wire logic                        i_q_full,
    output logic                             o_q_push,
    output mhed_pkg::t_item                  o_q_item
);
    import mhed_pkg::*;

    // Tag each request with whether its channel exists
    always_comb begin
        o_q_item.channel  = i_channel;
        o_q_item.sample   = i_sample;
        o_q_item.in_range = ({1'b0, i_channel} < (CH_W + 1)'(CHANNELS));
    end

    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full;

endmodule

`default_nettype wire

>>> rtl/mhed_back.sv
`default_nettype none

module mhed_back #(
    parameter int CHANNELS         = 6,
    parameter int BASELINE_SAMPLES = 20
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [mhed_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mhed_pkg::LVL_W-1:0]      i_cfg_data,
    input  wire logic                            i_q_empty,
    input  mhed_pkg::t_item                      i_q_item,
    output logic                                 o_q_pop,
    input  wire logic                            i_r_full,
    output logic                                 o_r_push,
    output mhed_pkg::t_result                    o_r_data
);
    import mhed_pkg::*;

    localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W   = $clog2(BASELINE_SAMPLES + 1);
    localparam int RECIP_W = DIV_SHIFT + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((2 ** DIV_SHIFT + BASELINE_SAMPLES - 1) / BASELINE_SAMPLES);

    logic [LVL_W-1:0] r_trigger, r_release;

    logic [SMP_W-1:0] r_base   [CHANNELS];
    logic [SUM_W-1:0] r_sum    [CHANNELS];
    logic [CNT_W-1:0] r_count  [CHANNELS];
    logic             r_active [CHANNELS];

    logic             r_div_pend;
    logic [IDX_W-1:0] r_div_ch;

    logic [IDX_W-1:0]  idx;
    logic              hazard, go;
    logic              calib, start_div;
    logic [SUM_W-1:0]  sum_n;
    logic [CNT_W-1:0]  cnt_n;
    logic [SMP_W-1:0]  base, diff;
    logic              act_old, act_n, ev;
    logic [PROD_W-1:0] prod;

    assign idx = i_q_item.channel[IDX_W-1:0];

    // Hold the head while its channel's baseline is still being written
    assign hazard  = r_div_pend && i_q_item.in_range && (idx == r_div_ch);
    assign go      = !i_q_empty && !i_r_full && !hazard;
    assign o_q_pop = go;

    always_comb begin
        calib     = 1'b0;
        start_div = 1'b0;
        sum_n     = r_sum[idx];
        cnt_n     = r_count[idx];
        base      = r_base[idx];
        act_old   = r_active[idx];
        act_n     = act_old;
        ev        = 1'b0;
        diff      = '0;
        if (i_q_item.in_range) begin
            if (r_count[idx] < CNT_W'(BASELINE_SAMPLES)) begin
                calib = 1'b1;
                sum_n = r_sum[idx] + SUM_W'(i_q_item.sample);
                cnt_n = r_count[idx] + 1'b1;
                start_div = (cnt_n == CNT_W'(BASELINE_SAMPLES));
            end else begin
                diff = (i_q_item.sample >= base) ? (i_q_item.sample - base)
                                                 : (base - i_q_item.sample);
                if (!act_old) begin
                    if (diff > r_trigger) begin
                        act_n = 1'b1;
                        ev    = 1'b1;
                    end
                end else if (diff < r_release) begin
                    act_n = 1'b0;
                end
            end
        end
    end

    // Mean of the finished sum, taken from the stored sum of the pending channel
    always_comb begin
        prod = PROD_W'(r_sum[r_div_ch]) * PROD_W'(RECIP);
    end

    always_comb begin
        o_r_push              = go;
        o_r_data.channel_echo = i_q_item.channel;
        o_r_data.calibrating  = calib;
        o_r_data.event_res    = ev;
        o_r_data.active       = (i_q_item.in_range && !calib) ? act_n : 1'b0;
        o_r_data.difference   = diff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger <= DEF_TRIGGER;
            r_release <= DEF_RELEASE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_TRIGGER: r_trigger <= i_cfg_data;
                REG_RELEASE: r_release <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_pend <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_sum[i]    <= '0;
                r_count[i]  <= '0;
                r_active[i] <= 1'b0;
            end
        end else begin
            r_div_pend <= go && start_div;
            if (go && i_q_item.in_range) begin
                r_sum[idx]    <= sum_n;
                r_count[idx]  <= cnt_n;
                r_active[idx] <= act_n;
            end
        end
    end

    // Store the mean as the baseline in the cycle after the last baseline sample
    always_ff @(posedge i_clk) begin
        r_div_ch <= idx;
        if (r_div_pend) begin
            r_base[r_div_ch] <= prod[DIV_SHIFT +: SMP_W];
        end
    end

endmodule

`default_nettype wire

>>> rtl/multichannel_hall_event_detector.sv
`default_nettype none

// Multichannel baseline and hysteresis event detector.
//
// Input requests: drive i_channel and i_sample with push; a request is taken
// at a rising edge with push high and full low. Results come out of a queue:
// while empty is low the oldest result sits on the o_ ports, and it leaves at
// a rising edge with pop high. Every request yields exactly one result.
// Levels: write i_cfg_data to register i_cfg_idx (0 trigger, 1 release) with
// i_cfg_we high; the write lands at that edge.
//
// A result enters the result queue when the back end takes its request off the request queue.
// Throughput: one request per cycle while the result queue has room, set by the
// read-modify-write of the per-channel state. A request on a channel right after
// the sample that completes that channel's baseline waits while the mean from
// the reciprocal multiplier is written back.
//
// Reset clears all counts, sums and channel states, empties both queues and
// loads the levels with 80 and 40. When the receiver stops popping, the result
// queue fills, the back end holds, then the request queue fills and full rises.
module multichannel_hall_event_detector #(
    parameter int CHANNELS         = mhed_pkg::DEF_CHANNELS,
    parameter int BASELINE_SAMPLES = mhed_pkg::DEF_BASELINE_SAMPLES
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [mhed_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mhed_pkg::LVL_W-1:0]      i_cfg_data,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [mhed_pkg::CH_W-1:0]       i_channel,
    input  wire logic [mhed_pkg::SMP_W-1:0]      i_sample,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [mhed_pkg::CH_W-1:0]            o_channel_echo,
    output logic                                 o_calibrating,
    output logic                                 o_event_res,
    output logic                                 o_active,
    output logic [mhed_pkg::SMP_W-1:0]           o_difference
);
    import mhed_pkg::*;

    localparam int ITEM_W = $bits(t_item);
    localparam int RES_W  = $bits(t_result);

    logic    fq_push, fq_full, fq_empty, fq_pop;
    t_item   fq_in, fq_out;
    logic    rq_push, rq_full;
    t_result rq_in, rq_out;

    // Front: tag requests and hand them to the request queue
    mhed_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_push    (push),
        .i_channel (i_channel),
        .i_sample  (i_sample),
        .o_full    (full),
        .i_q_full  (fq_full),
        .o_q_push  (fq_push),
        .o_q_item  (fq_in)
    );

    mhed_fifo #(
        .W     (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_data  (fq_in),
        .o_full  (fq_full),
        .i_pop   (fq_pop),
        .o_empty (fq_empty),
        .o_data  (fq_out)
    );

    // Back: update per-channel state and produce one result per request
    mhed_back #(
        .CHANNELS         (CHANNELS),
        .BASELINE_SAMPLES (BASELINE_SAMPLES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_empty  (fq_empty),
        .i_q_item   (fq_out),
        .o_q_pop    (fq_pop),
        .i_r_full   (rq_full),
        .o_r_push   (rq_push),
        .o_r_data   (rq_in)
    );

    // Result queue parts the back end from the receiver
    mhed_fifo #(
        .W     (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rq_push),
        .i_data  (rq_in),
        .o_full  (rq_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (rq_out)
    );

    assign o_channel_echo = rq_out.channel_echo;
    assign o_calibrating  = rq_out.calibrating;
    assign o_event_res    = rq_out.event_res;
    assign o_active       = rq_out.active;
    assign o_difference   = rq_out.difference;

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mhed_pkg::*;

    localparam int CHANNELS         = DEF_CHANNELS;
    localparam int BASELINE_SAMPLES = DEF_BASELINE_SAMPLES;
    localparam int ITEMS_PER_PHASE  = 170;    // in-range samples per level setting
    localparam int LEVEL_PHASES     = 9;      // phase 0 runs on the reset levels
    localparam int CYCLE_LIMIT      = 400000;

    // One row of the directed stimulus. Rows with typed set carry their
    // expected result; the rest are checked against the detector model.
    typedef struct packed {
        logic [CH_W-1:0]  ch;
        logic [SMP_W-1:0] smp;
        logic [5:0]       reps;
        logic             typed;
        logic             cal;
        logic             ev;
        logic             act;
        logic [SMP_W-1:0] diff;
    } t_stim_row;

    localparam int STIM_ROWS = 11;
    localparam t_stim_row STIM_TABLE [STIM_ROWS] = '{
        // channels past the last one: state untouched, all fields but the channel echo zero
        '{3'd6, 12'd4095, 6'd1,  1'b1, 1'b0, 1'b0, 1'b0, 12'd0},
        '{3'd7, 12'd0,    6'd1,  1'b1, 1'b0, 1'b0, 1'b0, 12'd0},
        // full baseline run on channel 0, baseline ends at zero
        '{3'd0, 12'd0,    6'd20, 1'b1, 1'b1, 1'b0, 1'b0, 12'd0},
        // largest difference triggers
        '{3'd0, 12'd4095, 6'd1,  1'b1, 1'b0, 1'b1, 1'b1, 12'd4095},
        // zero difference releases
        '{3'd0, 12'd0,    6'd1,  1'b1, 1'b0, 1'b0, 1'b0, 12'd0},
        // exactly at trigger: stays idle; one above: triggers
        '{3'd0, 12'd80,   6'd1,  1'b1, 1'b0, 1'b0, 1'b0, 12'd80},
        '{3'd0, 12'd81,   6'd1,  1'b1, 1'b0, 1'b1, 1'b1, 12'd81},
        // exactly at release: holds; one below: releases
        '{3'd0, 12'd40,   6'd1,  1'b1, 1'b0, 1'b0, 1'b1, 12'd40},
        '{3'd0, 12'd39,   6'd1,  1'b1, 1'b0, 1'b0, 1'b0, 12'd39},
        // first baseline samples on other channels
        '{3'd3, 12'd2730, 6'd1,  1'b0, 1'b0, 1'b0, 1'b0, 12'd0},
        '{3'd5, 12'd1365, 6'd1,  1'b0, 1'b0, 1'b0, 1'b0, 12'd0}
    };

    // DUT ports, the inputs driven to known values from time zero
    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_cfg_we   = 1'b0;
    t_cfg_reg         i_cfg_idx  = REG_TRIGGER;
    logic [LVL_W-1:0] i_cfg_data = '0;
    logic             push       = 1'b0;
    logic [CH_W-1:0]  i_channel  = '0;
    logic [SMP_W-1:0] i_sample   = '0;
    logic             pop        = 1'b0;
    logic             full;
    logic             empty;
    logic [CH_W-1:0]  o_channel_echo;
    logic             o_calibrating;
    logic             o_event_res;
    logic             o_active;
    logic [SMP_W-1:0] o_difference;

    // Detector model state: levels, per-channel baseline build-up and state
    logic [LVL_W-1:0] trig_level = DEF_TRIGGER;
    logic [LVL_W-1:0] rel_level  = DEF_RELEASE;
    logic [SMP_W-1:0] base_mean  [CHANNELS];
    logic [SUM_W-1:0] base_sum   [CHANNELS];
    logic [5:0]       base_count [CHANNELS];
    logic             ch_active  [CHANNELS];
    int               cal_center [CHANNELS];

    t_result detection_q [$];    // predicted results, oldest first

    int fail_count    = 0;
    int bad_results   = 0;
    int checked_count = 0;
    int sent_count    = 0;
    int stray_count   = 0;
    int event_count   = 0;
    int release_count = 0;
    int setting_count = 1;

    always #6 i_clk = ~i_clk;

    multichannel_hall_event_detector dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_channel      (i_channel),
        .i_sample       (i_sample),
        .empty          (empty),
        .pop            (pop),
        .o_channel_echo (o_channel_echo),
        .o_calibrating  (o_calibrating),
        .o_event_res    (o_event_res),
        .o_active       (o_active),
        .o_difference   (o_difference)
    );

    // Advance the detector model by one accepted sample and return what the
    // block must report for it.
    function automatic t_result compute_detection(input logic [CH_W-1:0] ch,
                                                  input logic [SMP_W-1:0] smp);
        t_result r;
        logic [SMP_W-1:0] base;
        r = '0;
        r.channel_echo = ch;
        if (ch < CHANNELS) begin
            if (base_count[ch] < BASELINE_SAMPLES) begin
                // still building the baseline: accumulate, set the mean on the last one
                r.calibrating  = 1'b1;
                base_sum[ch]   = base_sum[ch] + SUM_W'(smp);
                base_count[ch] = base_count[ch] + 6'd1;
                if (base_count[ch] >= BASELINE_SAMPLES) begin
                    base_mean[ch] = SMP_W'(base_sum[ch] / BASELINE_SAMPLES);
                end
            end else begin
                base = base_mean[ch];
                r.difference = (smp >= base) ? smp - base : base - smp;
                // idle test first; release only applies to an already active channel
                if (!ch_active[ch]) begin
                    if (r.difference > trig_level) begin
                        ch_active[ch] = 1'b1;
                        r.event_res   = 1'b1;
                        event_count++;
                    end
                end else if (r.difference < rel_level) begin
                    ch_active[ch] = 1'b0;
                    release_count++;
                end
                r.active = ch_active[ch];
            end
        end
        return r;
    endfunction

    function automatic logic [SMP_W-1:0] clamp_sample(input int v);
        if (v < 0) begin
            return '0;
        end
        if (v > 4095) begin
            return '1;
        end
        return SMP_W'(v);
    endfunction

    // Draw a sample that lands where the hysteresis decisions are made: close to the baseline,
    // right at either level, within the larger level, or anywhere; near cal_center while calibrating.
    function automatic logic [SMP_W-1:0] pick_sample(input logic [CH_W-1:0] ch);
        int mode;
        int offset;
        int lvl;
        mode = $urandom_range(0, 9);
        if (ch >= CHANNELS || mode < 2) begin
            return SMP_W'($urandom_range(0, 4095));
        end
        if (base_count[ch] < BASELINE_SAMPLES) begin
            return clamp_sample(cal_center[ch] + $urandom_range(0, 40) - 20);
        end
        if (mode < 5) begin
            lvl    = (trig_level > rel_level) ? trig_level : rel_level;
            offset = $urandom_range(0, lvl + 8);
        end else if (mode < 8) begin
            lvl    = $urandom_range(0, 1) ? trig_level : rel_level;
            offset = lvl + $urandom_range(0, 2) - 1;
        end else begin
            offset = $urandom_range(0, 10);
        end
        if ($urandom_range(0, 1)) begin
            offset = -offset;
        end
        return clamp_sample(int'(base_mean[ch]) + offset);
    endfunction

    // Offer one request, hold it until the block takes it, then log the
    // expected result. Keep push high across back-to-back requests.
    bit steady_tx = 1'b0;

    task automatic send_request(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] smp,
                                input logic use_typed, input t_result typed_res);
        int gap;
        t_result predicted;
        if ($urandom_range(0, 39) == 0) begin
            steady_tx = !steady_tx;
        end
        gap = steady_tx ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_channel <= ch;
        i_sample  <= smp;
        do @(posedge i_clk); while (full);
        predicted = compute_detection(ch, smp);
        detection_q.push_back(use_typed ? typed_res : predicted);
        sent_count++;
        if (ch >= CHANNELS) begin
            stray_count++;
        end
    endtask

    // Drop push and wait until every request has come back and the block has settled.
    task automatic drain_requests();
        push <= 1'b0;
        while (detection_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both levels on consecutive edges; the block must be idle here.
    task automatic write_levels(input logic [LVL_W-1:0] trig, input logic [LVL_W-1:0] rel);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_TRIGGER;
        i_cfg_data <= trig;
        @(posedge i_clk);
        i_cfg_idx  <= REG_RELEASE;
        i_cfg_data <= rel;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        trig_level = trig;
        rel_level  = rel;
        setting_count++;
    endtask

    // Random phase: mostly in-range channels, a tenth of requests on the
    // two channel codes past the last channel as noise.
    task automatic run_random_phase();
        int in_range;
        logic [CH_W-1:0] ch;
        in_range = 0;
        while (in_range < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 9) == 0) begin
                ch = CH_W'($urandom_range(CHANNELS, 7));
            end else begin
                ch = CH_W'($urandom_range(0, CHANNELS - 1));
                in_range++;
            end
            send_request(ch, pick_sample(ch), 1'b0, '0);
        end
    endtask

    task automatic report_field(input string name, input int want, input int got,
                                inout bit bad);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
            bad = 1'b1;
        end
    endtask

    // Result side: stall a random number of cycles per result, then pop and
    // compare against the oldest prediction.
    initial begin
        int stall;
        bit steady_rx;
        bit bad;
        t_result want;
        steady_rx = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                steady_rx = !steady_rx;
            end
            stall = steady_rx ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            if (detection_q.size() == 0) begin
                $error("result on channel %0d with no request waiting", o_channel_echo);
                fail_count++;
            end else begin
                want = detection_q.pop_front();
                bad  = 1'b0;
                report_field("channel_echo", want.channel_echo, o_channel_echo, bad);
                report_field("calibrating", want.calibrating, o_calibrating, bad);
                report_field("event_res", want.event_res, o_event_res, bad);
                report_field("active", want.active, o_active, bad);
                report_field("difference", want.difference, o_difference, bad);
                if (bad) begin
                    bad_results++;
                end
                checked_count++;
            end
        end
    end

    // Watchdog: end the run if it stalls far past the slowest legal run.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $error("timeout with %0d results outstanding", detection_q.size());
        $display("multichannel_hall_event_detector regression: fail");
        $finish;
    end

    // Main sequence: reset, directed table on the reset levels, then random
    // phases across level settings, extremes and inverted hysteresis included.
    initial begin
        t_result typed_res;
        logic [LVL_W-1:0] trig;
        logic [LVL_W-1:0] rel;
        for (int c = 0; c < CHANNELS; c++) begin
            base_mean[c]  = '0;
            base_sum[c]   = '0;
            base_count[c] = '0;
            ch_active[c]  = 1'b0;
            cal_center[c] = $urandom_range(0, 4095);
        end
        // pin one channel's baseline near full scale
        cal_center[1] = 4085;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (STIM_TABLE[row]) begin
            typed_res.channel_echo = STIM_TABLE[row].ch;
            typed_res.calibrating  = STIM_TABLE[row].cal;
            typed_res.event_res    = STIM_TABLE[row].ev;
            typed_res.active       = STIM_TABLE[row].act;
            typed_res.difference   = STIM_TABLE[row].diff;
            repeat (STIM_TABLE[row].reps) begin
                send_request(STIM_TABLE[row].ch, STIM_TABLE[row].smp,
                             STIM_TABLE[row].typed, typed_res);
            end
        end

        for (int phase = 0; phase < LEVEL_PHASES; phase++) begin
            if (phase != 0) begin
                drain_requests();
                case (phase)
                    1: begin trig = '0; rel = '0; end          // trigger on any change, never release
                    2: begin trig = '1; rel = '1; end          // never trigger, release almost always
                    3: begin trig = '0; rel = '1; end          // release above trigger
                    4: begin trig = '1; rel = '0; end          // frozen states
                    5: begin trig = DEF_TRIGGER; rel = DEF_RELEASE; end
                    6: begin trig = 12'd300; rel = 12'd150; end
                    7: begin
                        trig = LVL_W'($urandom_range(0, 600));
                        rel  = LVL_W'($urandom_range(0, 600));
                    end
                    default: begin
                        trig = LVL_W'($urandom_range(0, 400));
                        rel  = trig;
                    end
                endcase
                write_levels(trig, rel);
            end
            run_random_phase();
        end
        drain_requests();

        $display("checked %0d results (%0d mismatching) from %0d requests (%0d on unused channels)",
                 checked_count, bad_results, sent_count, stray_count);
        $display("over %0d level settings: %0d events, %0d releases",
                 setting_count, event_count, release_count);
        if (fail_count == 0 && detection_q.size() == 0) begin
            $display("multichannel_hall_event_detector regression: pass");
        end else begin
            $display("multichannel_hall_event_detector regression: fail");
        end
        $finish;
    end

endmodule
